// File: rtl/three_wheel_swerve_kinematics_defines.svh
// Assertion macros shared by the swerve kinematics checker.
`ifndef THREE_WHEEL_SWERVE_KINEMATICS_DEFINES_SVH
`define THREE_WHEEL_SWERVE_KINEMATICS_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define TWSK_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("twsk: next-cycle assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define TWSK_ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("twsk: same-cycle assertion failed");

`endif

// File: rtl/twsk_pkg.sv
// Types, constants and tables of the three-wheel swerve kinematics block.
package twsk_pkg;

  localparam int WHEEL_COUNT = 3;
  localparam int ENC_BITS    = 13;
  localparam int ANG_BITS    = 20;
  localparam int ANG_SHIFT   = ANG_BITS - ENC_BITS;

  localparam int VEL_W    = 16;
  localparam int RADIUS_W = 10;
  localparam int RATIO_W  = 16;
  localparam int SPEED_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam int VEC_W   = 32;
  localparam int CPROD_W = 48;
  localparam int Z_W     = ANG_BITS + 2;

  localparam int CORDIC_ITERS = 17;
  localparam int CNT_W        = $clog2(CORDIC_ITERS);
  localparam int ATAN_W       = 18;

  localparam int RAD_W       = 60;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 4;
  localparam int SQRT_CYCLES = ROOT_W / 2;
  localparam int SQRT_CNT_W  = $clog2(SQRT_CYCLES);

  localparam int SPD_W      = SPEED_W - 1;
  localparam int PROD_W     = ROOT_W + RATIO_W;

  // Division by 512000 = 2^12 * 125. Below the saturation limit the value
  // shifted right by 12 fits in 22 bits, where multiplying by ceil(2^29 / 125)
  // and shifting right by 29 gives the exact floor quotient by 125.
  localparam int DIV_PRE_SHIFT = 12;
  localparam int QN_W          = 22;
  localparam int RECIP_W       = 23;
  localparam int QPROD_W       = QN_W + RECIP_W;
  localparam int RECIP_SHIFT   = 29;
  localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(4294968);

  localparam int COS30_Q16  = 56756;
  localparam int ROUND_Q15  = 16384;
  localparam int SPEED_DIV  = 512000;
  localparam int SPEED_HALF = 256000;
  localparam int VEL_SCALE  = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_FRONT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LEFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_RIGHT = 3'd4;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(200);
  localparam logic [RATIO_W-1:0]  RATIO_RESET  = RATIO_W'(256);

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic [ENC_BITS-1:0] enc_t;

  localparam enc_t HALF_TURN = enc_t'(1 << (ENC_BITS - 1));
  localparam logic signed [ENC_BITS:0] QUARTER_S = (ENC_BITS + 1)'(1 << (ENC_BITS - 2));

  localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(SPEED_DIV) << SPD_W;

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic [SPD_W-1:0] speed;
    enc_t             ticks;
  } lane_res_t;

  // Arctangent of 2^-i in units of 2^-20 turn.
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 18'd131072;
      5'd1:    v = 18'd77376;
      5'd2:    v = 18'd40884;
      5'd3:    v = 18'd20753;
      5'd4:    v = 18'd10417;
      5'd5:    v = 18'd5213;
      5'd6:    v = 18'd2607;
      5'd7:    v = 18'd1304;
      5'd8:    v = 18'd652;
      5'd9:    v = 18'd326;
      5'd10:   v = 18'd163;
      5'd11:   v = 18'd81;
      5'd12:   v = 18'd41;
      5'd13:   v = 18'd20;
      5'd14:   v = 18'd10;
      5'd15:   v = 18'd5;
      5'd16:   v = 18'd3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/three_wheel_swerve_kinematics.sv
// Top level of the three-wheel swerve drive inverse kinematics block.
//
//   channel | handshake                      | payload
//   --------+--------------------------------+----------------------------------------
//   input   | in_valid_i / in_stall_o        | vel_x, vel_y, yaw_rate, enc_*
//   output  | out_valid_o / out_stall_i      | speed_*, angle_*
//   config  | cfg_we_i                       | cfg_idx_i, cfg_wdata_i
//
// An item passes from transfer in to result through the front end, then per lane squaring,
// square root, a multiply and the reciprocal division, the flag that marks the lane done,
// and last the load of the output register.
// One item is in flight at a time; the next is taken once the result sits in the output
// register, so a waiting result does not block input.
// Reset clears all control state, the held targets to 0 and the direction flags to +1.
module three_wheel_swerve_kinematics import twsk_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [VEL_W-1:0]    vel_x_i,
  input  logic signed [VEL_W-1:0]    vel_y_i,
  input  logic signed [VEL_W-1:0]    yaw_rate_i,
  input  logic [ENC_BITS-1:0]        enc_front_i,
  input  logic [ENC_BITS-1:0]        enc_left_i,
  input  logic [ENC_BITS-1:0]        enc_right_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SPEED_W-1:0]  speed_front_o,
  output logic signed [SPEED_W-1:0]  speed_left_o,
  output logic signed [SPEED_W-1:0]  speed_right_o,
  output logic [ENC_BITS-1:0]        angle_front_o,
  output logic [ENC_BITS-1:0]        angle_left_o,
  output logic [ENC_BITS-1:0]        angle_right_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic in_acc, prep_done, fire, fire_req;
  logic [RADIUS_W-1:0] radius_q;
  logic [RATIO_W-1:0]  ratio_q;
  enc_t off_q [WHEEL_COUNT];
  enc_t enc_q [WHEEL_COUNT];
  logic active_q;
  vec_t wx [WHEEL_COUNT];
  vec_t wy [WHEEL_COUNT];
  logic [WHEEL_COUNT-1:0] lane_done;
  lane_res_t lane_res [WHEEL_COUNT];
  logic signed [SPEED_W-1:0] speed [WHEEL_COUNT];
  enc_t angle [WHEEL_COUNT];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fire_req   = (state_q == S_RUN) && (&lane_done);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_PREP;
      S_PREP:  if (prep_done) state_d = S_RUN;
      S_RUN:   if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      radius_q <= RADIUS_RESET;
      ratio_q  <= RATIO_RESET;
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        off_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RADIUS:    radius_q <= cfg_wdata_i[RADIUS_W-1:0];
          REG_RATIO:     ratio_q  <= cfg_wdata_i[RATIO_W-1:0];
          REG_OFF_FRONT: off_q[0] <= cfg_wdata_i[ENC_BITS-1:0];
          REG_OFF_LEFT:  off_q[1] <= cfg_wdata_i[ENC_BITS-1:0];
          REG_OFF_RIGHT: off_q[2] <= cfg_wdata_i[ENC_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      enc_q[0] <= enc_front_i;
      enc_q[1] <= enc_left_i;
      enc_q[2] <= enc_right_i;
      active_q <= (vel_x_i != '0) || (vel_y_i != '0) || (yaw_rate_i != '0);
    end
  end

  twsk_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .vel_x_i    (vel_x_i),
    .vel_y_i    (vel_y_i),
    .yaw_rate_i (yaw_rate_i),
    .radius_i   (radius_q),
    .done_o     (prep_done),
    .wx_o       (wx),
    .wy_o       (wy)
  );

  for (genvar g = 0; g < WHEEL_COUNT; g++) begin : g_lane
    twsk_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (prep_done),
      .wx_i    (wx[g]),
      .wy_i    (wy[g]),
      .ratio_i (ratio_q),
      .done_o  (lane_done[g]),
      .res_o   (lane_res[g])
    );
  end

  twsk_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_req_i  (fire_req),
    .active_i    (active_q),
    .res_i       (lane_res),
    .enc_i       (enc_q),
    .offset_i    (off_q),
    .out_stall_i (out_stall_i),
    .fire_o      (fire),
    .out_valid_o (out_valid_o),
    .speed_o     (speed),
    .angle_o     (angle)
  );

  assign speed_front_o = speed[0];
  assign speed_left_o  = speed[1];
  assign speed_right_o = speed[2];
  assign angle_front_o = angle[0];
  assign angle_left_o  = angle[1];
  assign angle_right_o = angle[2];

endmodule

// File: rtl/twsk_prep.sv
// Front end: scales the command and forms the three wheel velocity vectors.
module twsk_prep import twsk_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [VEL_W-1:0]    vel_x_i,
  input  logic signed [VEL_W-1:0]    vel_y_i,
  input  logic signed [VEL_W-1:0]    yaw_rate_i,
  input  logic        [RADIUS_W-1:0] radius_i,
  output logic                       done_o,
  output vec_t                       wx_o [WHEEL_COUNT],
  output vec_t                       wy_o [WHEEL_COUNT]
);

  logic s1_q, s2_q, done_q;
  vec_t vx1_q, vy1_q, t1_q;
  vec_t vx2_q, vy2_q, t2_q, c2_q;
  vec_t vx_d, vy_d, t_d, c_d;
  vec_t wx_q [WHEEL_COUNT];
  vec_t wy_q [WHEEL_COUNT];
  logic [VEC_W-1:0]   t_abs;
  logic [CPROD_W-1:0] cprod;
  logic [CPROD_W-1:0] cmag;

  always_comb begin
    vx_d  = vec_t'(vel_x_i) * vec_t'(VEL_SCALE);
    vy_d  = vec_t'(vel_y_i) * vec_t'(VEL_SCALE);
    t_d   = vec_t'(yaw_rate_i) * vec_t'({1'b0, radius_i});
    // Rotation term times 2*cos30, rounded half away from zero.
    t_abs = t1_q[VEC_W-1] ? VEC_W'(-t1_q) : VEC_W'(t1_q);
    cprod = CPROD_W'(t_abs) * CPROD_W'(COS30_Q16);
    cmag  = (cprod + CPROD_W'(ROUND_Q15)) >> 15;
    c_d   = t1_q[VEC_W-1] ? -vec_t'(cmag[VEC_W-1:0]) : vec_t'(cmag[VEC_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      vx1_q <= vx_d;
      vy1_q <= vy_d;
      t1_q  <= t_d;
    end
    if (s1_q) begin
      vx2_q <= vx1_q;
      vy2_q <= vy1_q;
      t2_q  <= t1_q;
      c2_q  <= c_d;
    end
    if (s2_q) begin
      wx_q[0] <= vx2_q;
      wy_q[0] <= vy2_q + (t2_q <<< 1);
      wx_q[1] <= vx2_q + c2_q;
      wy_q[1] <= vy2_q - t2_q;
      wx_q[2] <= vx2_q - c2_q;
      wy_q[2] <= vy2_q - t2_q;
    end
  end

  assign done_o = done_q;
  assign wx_o   = wx_q;
  assign wy_o   = wy_q;

endmodule

// File: rtl/twsk_lane.sv
// One wheel lane: square root of the squared vector length, speed scaling and CORDIC angle.
module twsk_lane import twsk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  vec_t               wx_i,
  input  vec_t               wy_i,
  input  logic [RATIO_W-1:0] ratio_i,
  output logic               done_o,
  output lane_res_t          res_o
);

  logic run_q, done_q, sq_pend_q, sum_pend_q, rt_busy_q, mul_pend_q;
  logic first_q, cor_busy_q;
  logic [SQRT_CNT_W-1:0] rt_cnt_q;
  logic [CNT_W-1:0]      cor_cnt_q;

  logic signed [2*VEC_W-1:0] sqx_q, sqy_q;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_q, rem_d, rem_sh, trial;

  logic [PROD_W-1:0]  drem_q;
  logic [QPROD_W-1:0] qprod;
  logic [SPD_W-1:0]   quo_q;
  logic               sat_q;

  vec_t cx_q, cy_q, cx_d, cy_d, xs, ys, cx_init, cy_init;
  logic signed [Z_W-1:0] cz_q, cz_d, step_ang;
  logic zero_q;
  logic [ANG_BITS:0] z_round;
  logic idle;

  // Square root, two result digits per cycle.
  always_comb begin
    root_d = root_q;
    rem_d  = rem_q;
    rad_d  = rad_q;
    rem_sh = '0;
    trial  = '0;
    for (int k = 0; k < 2; k++) begin
      rem_sh = {rem_d[REM_W-3:0], rad_d[RAD_W-1 -: 2]};
      rad_d  = rad_d << 2;
      trial  = REM_W'({root_d, 2'b01});
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_d[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_d[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Division by the rpm constant: drop the power of two, then scale by the reciprocal of 125.
  assign qprod = QPROD_W'(drem_q[DIV_PRE_SHIFT +: QN_W]) * QPROD_W'(RECIP_125);

  // CORDIC vectoring step.
  always_comb begin
    xs       = cx_q >>> cor_cnt_q;
    ys       = cy_q >>> cor_cnt_q;
    step_ang = Z_W'(signed'({1'b0, atan_entry(cor_cnt_q)}));
    if (!cy_q[VEC_W-1]) begin
      cx_d = cx_q + ys;
      cy_d = cy_q - xs;
      cz_d = cz_q + step_ang;
    end else begin
      cx_d = cx_q - ys;
      cy_d = cy_q + xs;
      cz_d = cz_q - step_ang;
    end
    cx_init = wx_i[VEC_W-1] ? -wx_i : wx_i;
    cy_init = wx_i[VEC_W-1] ? -wy_i : wy_i;
  end

  assign idle = !(sq_pend_q || sum_pend_q || rt_busy_q || mul_pend_q || first_q ||
                  cor_busy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      done_q     <= 1'b0;
      sq_pend_q  <= 1'b0;
      sum_pend_q <= 1'b0;
      rt_busy_q  <= 1'b0;
      rt_cnt_q   <= '0;
      mul_pend_q <= 1'b0;
      first_q    <= 1'b0;
      cor_busy_q <= 1'b0;
      cor_cnt_q  <= '0;
    end else begin
      sq_pend_q  <= start_i;
      sum_pend_q <= sq_pend_q;
      mul_pend_q <= rt_busy_q && (rt_cnt_q == SQRT_CNT_W'(SQRT_CYCLES - 1));
      first_q    <= mul_pend_q;

      if (sum_pend_q) begin
        rt_busy_q <= 1'b1;
        rt_cnt_q  <= '0;
      end else if (rt_busy_q) begin
        if (rt_cnt_q == SQRT_CNT_W'(SQRT_CYCLES - 1)) begin
          rt_busy_q <= 1'b0;
        end
        rt_cnt_q <= rt_cnt_q + 1'b1;
      end

      if (start_i) begin
        cor_busy_q <= 1'b1;
        cor_cnt_q  <= '0;
      end else if (cor_busy_q) begin
        if (cor_cnt_q == CNT_W'(CORDIC_ITERS - 1)) begin
          cor_busy_q <= 1'b0;
        end
        cor_cnt_q <= cor_cnt_q + 1'b1;
      end

      if (start_i) begin
        run_q  <= 1'b1;
        done_q <= 1'b0;
      end else if (run_q && idle) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sqx_q  <= wx_i * wx_i;
      sqy_q  <= wy_i * wy_i;
      cx_q   <= cx_init;
      cy_q   <= cy_init;
      cz_q   <= wx_i[VEC_W-1] ? (Z_W'(1) <<< (ANG_BITS - 1)) : '0;
      zero_q <= (wx_i == '0) && (wy_i == '0);
    end else if (cor_busy_q) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      cz_q <= cz_d;
    end

    if (sum_pend_q) begin
      rad_q  <= sqx_q[RAD_W-1:0] + sqy_q[RAD_W-1:0];
      root_q <= '0;
      rem_q  <= '0;
    end else if (rt_busy_q) begin
      rad_q  <= rad_d;
      root_q <= root_d;
      rem_q  <= rem_d;
    end

    if (mul_pend_q) begin
      drem_q <= PROD_W'(root_q) * PROD_W'(ratio_i) + PROD_W'(SPEED_HALF);
    end

    // A quotient of 2^15 or more saturates.
    if (first_q) begin
      sat_q <= drem_q >= SAT_LIMIT;
      quo_q <= qprod[RECIP_SHIFT +: SPD_W];
    end
  end

  assign z_round     = {1'b0, cz_q[ANG_BITS-1:0]} + (ANG_BITS + 1)'(1 << (ANG_SHIFT - 1));
  assign res_o.speed = sat_q ? {SPD_W{1'b1}} : quo_q;
  assign res_o.ticks = zero_q ? '0 : z_round[ANG_BITS-1:ANG_SHIFT];
  assign done_o      = done_q;

endmodule

// File: rtl/twsk_merge.sv
// Merging stage: offsets, shortest-path steering, held state and output register.
module twsk_merge import twsk_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_req_i,
  input  logic                      active_i,
  input  lane_res_t                 res_i    [WHEEL_COUNT],
  input  enc_t                      enc_i    [WHEEL_COUNT],
  input  enc_t                      offset_i [WHEEL_COUNT],
  input  logic                      out_stall_i,
  output logic                      fire_o,
  output logic                      out_valid_o,
  output logic signed [SPEED_W-1:0] speed_o  [WHEEL_COUNT],
  output enc_t                      angle_o  [WHEEL_COUNT]
);

  logic fire;
  logic out_valid_q;
  enc_t held_q  [WHEEL_COUNT];
  logic dir_q   [WHEEL_COUNT];
  enc_t ang_d   [WHEEL_COUNT];
  logic dir_d   [WHEEL_COUNT];
  logic signed [SPEED_W-1:0] spd_d [WHEEL_COUNT];
  logic signed [SPEED_W-1:0] spd_q [WHEEL_COUNT];
  enc_t ang_q   [WHEEL_COUNT];

  assign fire = fire_req_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    enc_t tgt;
    logic signed [ENC_BITS:0] diff;
    logic move_hi, move_lo;
    logic [SPEED_W-1:0] mag;
    for (int k = 0; k < WHEEL_COUNT; k++) begin
      tgt     = offset_i[k] + res_i[k].ticks;
      diff    = signed'({1'b0, tgt}) - signed'({1'b0, enc_i[k]});
      move_hi = diff > QUARTER_S;
      move_lo = diff < -QUARTER_S;
      if (active_i) begin
        ang_d[k] = move_hi ? (tgt - HALF_TURN) : (move_lo ? (tgt + HALF_TURN) : tgt);
        dir_d[k] = move_hi || move_lo;
      end else begin
        ang_d[k] = held_q[k];
        dir_d[k] = dir_q[k];
      end
      mag      = {1'b0, res_i[k].speed};
      spd_d[k] = dir_d[k] ? signed'(mag) : -signed'(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < WHEEL_COUNT; k++) begin
        held_q[k] <= '0;
        dir_q[k]  <= 1'b1;
      end
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        for (int k = 0; k < WHEEL_COUNT; k++) begin
          held_q[k] <= ang_d[k];
          dir_q[k]  <= dir_d[k];
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      spd_q <= spd_d;
      ang_q <= ang_d;
    end
  end

  assign fire_o      = fire;
  assign out_valid_o = out_valid_q;
  assign speed_o     = spd_q;
  assign angle_o     = ang_q;

endmodule

// File: rtl/twsk_chk.sv
// Port-level checker for the swerve kinematics block, with its bind.
`include "three_wheel_swerve_kinematics_defines.svh"

module twsk_chk import twsk_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [SPEED_W-1:0] speed_front_o,
  input logic signed [SPEED_W-1:0] speed_left_o,
  input logic signed [SPEED_W-1:0] speed_right_o,
  input logic [ENC_BITS-1:0]       angle_front_o,
  input logic [ENC_BITS-1:0]       angle_left_o,
  input logic [ENC_BITS-1:0]       angle_right_o
);

  // A stalled result stays valid.
  `TWSK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its payload.
  `TWSK_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(speed_front_o) && $stable(speed_left_o) && $stable(speed_right_o) && $stable(angle_front_o) && $stable(angle_left_o) && $stable(angle_right_o))

  // After an input transfer the block is busy with that item.
  `TWSK_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result only appears at the end of an item's work.
  `TWSK_ASSERT_SAME(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind three_wheel_swerve_kinematics twsk_chk u_twsk_chk (.*);
